>>> rtl/keyframe_curve_interpolator_macros.svh
// ============================================================================
// Keyframe curve interpolator assertion macros
// Short forms for clocked assertions that are disabled while reset is active.
// ============================================================================
`ifndef KEYFRAME_CURVE_INTERPOLATOR_MACROS_SVH
`define KEYFRAME_CURVE_INTERPOLATOR_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define KCI_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define KCI_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/kci_pkg.sv
// ============================================================================
// Keyframe curve interpolator package
// Widths, codes, point and control types shared by the interpolator modules.
// ============================================================================
package kci_pkg;

    localparam int MAX_POINTS = 16;
    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);
    localparam int TIME_W     = 17;
    localparam int SCALE_W    = 16;
    localparam int U_W        = 16;
    localparam int MUL_A_W    = 20;
    localparam int MUL_B_W    = 18;
    localparam int ACC_W      = 40;

    typedef logic [TIME_W-1:0]         ktime_t;
    typedef logic signed [SCALE_W-1:0] scale_t;
    typedef logic [U_W-1:0]            frac_t;

    localparam ktime_t T_ONE     = 17'h10000;
    localparam ktime_t T_ZERO    = 17'h00000;
    localparam scale_t SCALE_ONE = 16'sd256;

    localparam logic [1:0] MODE_LINEAR = 2'd0;
    localparam logic [1:0] MODE_CURVE  = 2'd1;

    localparam logic [1:0] CFG_MODE  = 2'd0;
    localparam logic [1:0] CFG_START = 2'd1;
    localparam logic [1:0] CFG_END   = 2'd2;

    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_EVAL   = 1'b1;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    typedef struct packed {
        ktime_t pt_time;
        scale_t pt_scale;
    } point_t;

    typedef struct packed {
        logic en;
        logic clr;
    } mac_ctl_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_INS_RD,
        ST_INS_CMP,
        ST_SHIFT_RD,
        ST_SHIFT_WR,
        ST_EV_RD,
        ST_EV_STEP,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_LIN_MUL,
        ST_LIN_FIN,
        ST_S2_MUL,
        ST_S2_CAP,
        ST_S3_MUL,
        ST_S3_CAP,
        ST_W0,
        ST_W1,
        ST_W2,
        ST_W3,
        ST_CR_FIN,
        ST_DONE
    } state_t;

endpackage

>>> rtl/keyframe_curve_interpolator.sv
// ============================================================================
// Keyframe curve interpolator
// Sorted control point table with linear and Catmull-Rom scale evaluation.
// ============================================================================
// The block holds up to 16 user control points (Q1.16 time, Q8.8 scale) in a
// small table memory, plus fixed endpoints at time 0 and 1.0 taken from the
// start_scale and end_scale registers. One word is taken at a time and
// item_ready stays low until its result has been handed to the output
// register. An insert walks the table one point at a time, with a read and
// a compare per point, and, when it adds a point, moves each later point up
// one place with a read and a write per point. An evaluate walks the
// endpoint-merged list one point at a time until one point past the
// segment, then runs a 16-step divider for the position inside the segment
// and the shared multiplier for linear or Catmull-Rom; other mode codes give
// 1.0. The table walk and the single multiplier set the run time. The result
// register lets the next word be accepted while the previous result waits
// to be taken.
// ============================================================================
module keyframe_curve_interpolator (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [1:0]       cfg_addr,
    input  logic [15:0]      cfg_data,
    input  logic             item_valid,
    output logic             item_ready,
    input  logic             action,
    input  kci_pkg::ktime_t  life_time,
    input  kci_pkg::scale_t  point_scale,
    output logic             result_valid,
    input  logic             result_ready,
    output kci_pkg::scale_t  scale_out,
    output logic             status
);
    import kci_pkg::*;

    localparam logic signed [ACC_W-1:0] HALF16 = 40'sd32768;
    localparam logic signed [ACC_W-1:0] HALF17 = 40'sd65536;
    localparam logic signed [20:0]      W1_BIAS = 21'sd131072;

    function automatic scale_t sat16(input logic signed [ACC_W-1:0] v);
        scale_t r;
        if (v > 40'sd32767)
        begin
            r = 16'sh7fff;
        end
        else if (v < -40'sd32768)
        begin
            r = 16'sh8000;
        end
        else
        begin
            r = v[SCALE_W-1:0];
        end
        return r;
    endfunction

    // Configuration registers.
    logic [1:0] mode_reg;
    scale_t     start_reg;
    scale_t     end_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_LINEAR;
            start_reg <= SCALE_ONE;
            end_reg   <= SCALE_ONE;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                CFG_MODE:  mode_reg  <= cfg_data[1:0];
                CFG_START: start_reg <= cfg_data;
                CFG_END:   end_reg   <= cfg_data;
                default:   mode_reg  <= mode_reg;
            endcase
        end
    end

    // Sequencer state.
    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic [CNT_W-1:0]  pos_reg, pos_next;
    logic              end_done_reg, end_done_next;
    logic              found_reg, found_next;
    logic              out_valid_reg, out_valid_next;

    // Item and working registers.
    logic              act_reg, act_next;
    ktime_t            t_reg, t_next;
    scale_t            ps_reg, ps_next;
    scale_t            a_s_reg, a_s_next;
    ktime_t            b_t_reg, b_t_next;
    scale_t            b_s_reg, b_s_next;
    ktime_t            c_t_reg, c_t_next;
    scale_t            c_s_reg, c_s_next;
    scale_t            p3_reg, p3_next;
    frac_t             u_reg, u_next;
    logic [16:0]       s2_reg, s2_next;
    logic [16:0]       s3_reg, s3_next;
    scale_t            res_reg, res_next;
    logic              rst_reg, rst_next;
    scale_t            out_scale_reg, out_scale_next;
    logic              out_status_reg, out_status_next;

    // Memory, divider and multiplier hookup.
    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    point_t            ram_wdata;
    logic [CNT_W-1:0]  ram_raddr_full;
    point_t            ram_rdata;
    logic              div_start;
    ktime_t            div_num;
    ktime_t            div_den;
    logic              div_busy;
    frac_t             div_quot;
    mac_ctl_t          mac_ctl;
    logic signed [MUL_A_W-1:0] mac_a;
    logic signed [MUL_B_W-1:0] mac_b;
    logic signed [ACC_W-1:0]   mac_acc;

    // Element of the merged point list offered to the segment search.
    logic              elem_go;
    ktime_t            elem_t;
    scale_t            elem_s;

    // Rounded products and spline weights.
    logic signed [ACC_W-1:0] acc_r16;
    logic signed [ACC_W-1:0] acc_r17;
    logic signed [20:0]      s2x, s3x, ux;
    logic signed [20:0]      w0, w1, w2, w3;

    assign acc_r16 = (mac_acc + HALF16) >>> 16;
    assign acc_r17 = (mac_acc + HALF17) >>> 17;
    assign s2x = {4'b0, s2_reg};
    assign s3x = {4'b0, s3_reg};
    assign ux  = {5'b0, u_reg};
    assign w0  = (s2x <<< 1) - s3x - ux;
    assign w1  = (s3x <<< 1) + s3x - (s2x <<< 2) - s2x + W1_BIAS;
    assign w2  = (s2x <<< 2) - (s3x <<< 1) - s3x + ux;
    assign w3  = s3x - s2x;

    kci_ram u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr_full[IDX_W-1:0]),
        .rdata (ram_rdata)
    );

    kci_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .busy  (div_busy),
        .quot  (div_quot)
    );

    kci_mac u_mac (
        .clk (clk),
        .ctl (mac_ctl),
        .a   (mac_a),
        .b   (mac_b),
        .acc (mac_acc)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            idx_reg       <= '0;
            pos_reg       <= '0;
            end_done_reg  <= 1'b0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            idx_reg       <= idx_next;
            pos_reg       <= pos_next;
            end_done_reg  <= end_done_next;
            found_reg     <= found_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg        <= act_next;
        t_reg          <= t_next;
        ps_reg         <= ps_next;
        a_s_reg        <= a_s_next;
        b_t_reg        <= b_t_next;
        b_s_reg        <= b_s_next;
        c_t_reg        <= c_t_next;
        c_s_reg        <= c_s_next;
        p3_reg         <= p3_next;
        u_reg          <= u_next;
        s2_reg         <= s2_next;
        s3_reg         <= s3_next;
        res_reg        <= res_next;
        rst_reg        <= rst_next;
        out_scale_reg  <= out_scale_next;
        out_status_reg <= out_status_next;
    end

    assign ram_raddr_full = (state_reg == ST_SHIFT_RD) ? (idx_reg - CNT_W'(1)) : idx_reg;
    assign div_num        = t_reg - b_t_reg;
    assign div_den        = c_t_reg - b_t_reg;

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        idx_next        = idx_reg;
        pos_next        = pos_reg;
        end_done_next   = end_done_reg;
        found_next      = found_reg;
        out_valid_next  = out_valid_reg;
        act_next        = act_reg;
        t_next          = t_reg;
        ps_next         = ps_reg;
        a_s_next        = a_s_reg;
        b_t_next        = b_t_reg;
        b_s_next        = b_s_reg;
        c_t_next        = c_t_reg;
        c_s_next        = c_s_reg;
        p3_next         = p3_reg;
        u_next          = u_reg;
        s2_next         = s2_reg;
        s3_next         = s3_reg;
        res_next        = res_reg;
        rst_next        = rst_reg;
        out_scale_next  = out_scale_reg;
        out_status_next = out_status_reg;
        ram_we          = 1'b0;
        ram_waddr       = idx_reg[IDX_W-1:0];
        ram_wdata       = '{pt_time: t_reg, pt_scale: ps_reg};
        div_start       = 1'b0;
        mac_ctl         = '{en: 1'b0, clr: 1'b0};
        mac_a           = '0;
        mac_b           = '0;
        elem_go         = 1'b0;
        elem_t          = T_ONE;
        elem_s          = end_reg;

        // The output register empties when its word is taken.
        if (out_valid_reg && result_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    act_next      = action;
                    t_next        = life_time;
                    ps_next       = point_scale;
                    idx_next      = '0;
                    res_next      = '0;
                    rst_next      = STATUS_OK;
                    end_done_next = 1'b0;
                    found_next    = 1'b0;
                    // The start point always heads the merged list.
                    a_s_next      = start_reg;
                    b_t_next      = T_ZERO;
                    b_s_next      = start_reg;
                    if (action == ACT_EVAL)
                    begin
                        state_next = ST_EV_RD;
                    end
                    else if (life_time == T_ZERO || life_time == T_ONE)
                    begin
                        // Endpoint times are owned by the registers.
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_INS_RD;
                    end
                end
            end

            ST_INS_RD:
            begin
                if (idx_reg == cnt_reg)
                begin
                    if (cnt_reg == CNT_W'(MAX_POINTS))
                    begin
                        rst_next   = STATUS_FULL;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        pos_next   = cnt_reg;
                        state_next = ST_SHIFT_RD;
                    end
                end
                else
                begin
                    state_next = ST_INS_CMP;
                end
            end

            ST_INS_CMP:
            begin
                if (ram_rdata.pt_time == t_reg)
                begin
                    ram_we     = 1'b1;
                    state_next = ST_DONE;
                end
                else if (ram_rdata.pt_time > t_reg)
                begin
                    if (cnt_reg == CNT_W'(MAX_POINTS))
                    begin
                        rst_next   = STATUS_FULL;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        pos_next   = idx_reg;
                        idx_next   = cnt_reg;
                        state_next = ST_SHIFT_RD;
                    end
                end
                else
                begin
                    idx_next   = idx_reg + CNT_W'(1);
                    state_next = ST_INS_RD;
                end
            end

            ST_SHIFT_RD:
            begin
                if (idx_reg == pos_reg)
                begin
                    ram_we     = 1'b1;
                    cnt_next   = cnt_reg + CNT_W'(1);
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_SHIFT_WR;
                end
            end

            ST_SHIFT_WR:
            begin
                ram_we     = 1'b1;
                ram_wdata  = ram_rdata;
                idx_next   = idx_reg - CNT_W'(1);
                state_next = ST_SHIFT_RD;
            end

            ST_EV_RD:
            begin
                if (idx_reg == cnt_reg)
                begin
                    if (!end_done_reg)
                    begin
                        elem_go       = 1'b1;
                        end_done_next = 1'b1;
                    end
                    else if (found_reg)
                    begin
                        state_next = ST_DIV_GO;
                    end
                    else
                    begin
                        // At or past the last point: its scale in every mode.
                        res_next   = b_s_reg;
                        state_next = ST_DONE;
                    end
                end
                else
                begin
                    state_next = ST_EV_STEP;
                end
            end

            ST_EV_STEP:
            begin
                elem_go    = 1'b1;
                state_next = ST_EV_RD;
                if (!end_done_reg && ram_rdata.pt_time > T_ONE)
                begin
                    end_done_next = 1'b1;
                end
                else
                begin
                    elem_t   = ram_rdata.pt_time;
                    elem_s   = ram_rdata.pt_scale;
                    idx_next = idx_reg + CNT_W'(1);
                end
            end

            ST_DIV_GO:
            begin
                div_start  = 1'b1;
                state_next = ST_DIV_WAIT;
            end

            ST_DIV_WAIT:
            begin
                if (!div_busy)
                begin
                    u_next = div_quot;
                    case (mode_reg)
                        MODE_LINEAR: state_next = ST_LIN_MUL;
                        MODE_CURVE:  state_next = ST_S2_MUL;
                        default:
                        begin
                            res_next   = SCALE_ONE;
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end

            ST_LIN_MUL:
            begin
                mac_ctl    = '{en: 1'b1, clr: 1'b1};
                mac_a      = MUL_A_W'(u_reg);
                mac_b      = MUL_B_W'(c_s_reg) - MUL_B_W'(b_s_reg);
                state_next = ST_LIN_FIN;
            end

            ST_LIN_FIN:
            begin
                res_next   = sat16(acc_r16 + ACC_W'(b_s_reg));
                state_next = ST_DONE;
            end

            ST_S2_MUL:
            begin
                mac_ctl    = '{en: 1'b1, clr: 1'b1};
                mac_a      = MUL_A_W'(u_reg);
                mac_b      = MUL_B_W'(u_reg);
                state_next = ST_S2_CAP;
            end

            ST_S2_CAP:
            begin
                s2_next    = acc_r16[16:0];
                state_next = ST_S3_MUL;
            end

            ST_S3_MUL:
            begin
                mac_ctl    = '{en: 1'b1, clr: 1'b1};
                mac_a      = MUL_A_W'(s2_reg);
                mac_b      = MUL_B_W'(u_reg);
                state_next = ST_S3_CAP;
            end

            ST_S3_CAP:
            begin
                s3_next    = acc_r16[16:0];
                state_next = ST_W0;
            end

            ST_W0:
            begin
                mac_ctl    = '{en: 1'b1, clr: 1'b1};
                mac_a      = w0[MUL_A_W-1:0];
                mac_b      = MUL_B_W'(a_s_reg);
                state_next = ST_W1;
            end

            ST_W1:
            begin
                mac_ctl    = '{en: 1'b1, clr: 1'b0};
                mac_a      = w1[MUL_A_W-1:0];
                mac_b      = MUL_B_W'(b_s_reg);
                state_next = ST_W2;
            end

            ST_W2:
            begin
                mac_ctl    = '{en: 1'b1, clr: 1'b0};
                mac_a      = w2[MUL_A_W-1:0];
                mac_b      = MUL_B_W'(c_s_reg);
                state_next = ST_W3;
            end

            ST_W3:
            begin
                mac_ctl    = '{en: 1'b1, clr: 1'b0};
                mac_a      = w3[MUL_A_W-1:0];
                mac_b      = MUL_B_W'(p3_reg);
                state_next = ST_CR_FIN;
            end

            ST_CR_FIN:
            begin
                res_next   = sat16(acc_r17);
                state_next = ST_DONE;
            end

            ST_DONE:
            begin
                if (!out_valid_reg || result_ready)
                begin
                    out_valid_next  = 1'b1;
                    out_scale_next  = res_reg;
                    out_status_next = rst_reg;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Segment search over the merged list. The window keeps the point
        // before the segment, its two ends and the point after it.
        if (elem_go)
        begin
            if (found_reg)
            begin
                p3_next    = elem_s;
                state_next = ST_DIV_GO;
            end
            else if (t_reg < elem_t)
            begin
                found_next = 1'b1;
                c_t_next   = elem_t;
                c_s_next   = elem_s;
                p3_next    = elem_s;
            end
            else
            begin
                a_s_next = b_s_reg;
                b_t_next = elem_t;
                b_s_next = elem_s;
            end
        end
    end

    assign item_ready   = (state_reg == ST_IDLE);
    assign result_valid = out_valid_reg;
    assign scale_out    = out_scale_reg;
    assign status       = out_status_reg;

endmodule

>>> rtl/kci_ram.sv
// ============================================================================
// Point table memory
// One write port and one registered read port holding the control points.
// ============================================================================
module kci_ram (
    input  logic                  clk,
    input  logic                  we,
    input  logic [kci_pkg::IDX_W-1:0] waddr,
    input  kci_pkg::point_t       wdata,
    input  logic [kci_pkg::IDX_W-1:0] raddr,
    output kci_pkg::point_t       rdata
);
    import kci_pkg::*;

    point_t mem [MAX_POINTS];
    point_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/kci_div.sv
// ============================================================================
// Segment position divider
// Restoring divider giving floor(num * 2^16 / den), one quotient bit a cycle.
// ============================================================================
module kci_div (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  kci_pkg::ktime_t num,
    input  kci_pkg::ktime_t den,
    output logic            busy,
    output kci_pkg::frac_t  quot
);
    import kci_pkg::*;

    localparam int CW = $clog2(U_W + 1);

    logic [TIME_W:0]   rem_reg, rem_next;
    logic [TIME_W:0]   shifted;
    frac_t             q_reg, q_next;
    logic [CW-1:0]     cnt_reg, cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        q_reg   <= q_next;
    end

    always_comb
    begin
        rem_next = rem_reg;
        q_next   = q_reg;
        cnt_next = cnt_reg;
        shifted  = {rem_reg[TIME_W-1:0], 1'b0};
        if (start)
        begin
            rem_next = {1'b0, num};
            q_next   = '0;
            cnt_next = CW'(U_W);
        end
        else if (cnt_reg != '0)
        begin
            // The remainder stays below den, so one compare decides each bit.
            if (shifted >= {1'b0, den})
            begin
                rem_next = shifted - {1'b0, den};
                q_next   = {q_reg[U_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted;
                q_next   = {q_reg[U_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CW'(1);
        end
    end

    assign busy = (cnt_reg != '0);
    assign quot = q_reg;

endmodule

>>> rtl/kci_mac.sv
// ============================================================================
// Shared multiply-accumulate unit
// Signed multiplier with a registered accumulator, cleared or added per use.
// ============================================================================
module kci_mac (
    input  logic                                clk,
    input  kci_pkg::mac_ctl_t                   ctl,
    input  logic signed [kci_pkg::MUL_A_W-1:0]  a,
    input  logic signed [kci_pkg::MUL_B_W-1:0]  b,
    output logic signed [kci_pkg::ACC_W-1:0]    acc
);
    import kci_pkg::*;

    localparam int PW = MUL_A_W + MUL_B_W;

    logic signed [PW-1:0]    prod;
    logic signed [ACC_W-1:0] prod_x;
    logic signed [ACC_W-1:0] acc_reg;

    assign prod   = a * b;
    assign prod_x = {{(ACC_W - PW){prod[PW-1]}}, prod};

    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            acc_reg <= ctl.clr ? prod_x : (acc_reg + prod_x);
        end
    end

    assign acc = acc_reg;

endmodule

>>> rtl/kci_checker.sv
// ============================================================================
// Keyframe curve interpolator checker
// Port-level assertions on handshakes and result words, bound to the top.
// ============================================================================
`include "keyframe_curve_interpolator_macros.svh"

module kci_checker (
    input logic            clk,
    input logic            rst_n,
    input logic            item_valid,
    input logic            item_ready,
    input logic            result_valid,
    input logic            result_ready,
    input kci_pkg::scale_t scale_out,
    input logic            status
);
    import kci_pkg::*;

    // A stalled result word must hold.
    `KCI_ASSERT_NEXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(scale_out) && $stable(status), "result word changed while stalled")

    // One word at a time: the block is busy right after taking one.
    `KCI_ASSERT_NEXT(a_busy_after_accept, item_valid && item_ready, !item_ready, "input taken twice in a row")

    // A dropped insert reports a zero scale.
    `KCI_ASSERT_SAME(a_full_zero, result_valid && status == STATUS_FULL, scale_out == 16'sd0, "dropped insert with nonzero scale")

    // No result appears in the cycle right after a word is taken.
    `KCI_ASSERT_NEXT(a_no_instant, item_valid && item_ready && !result_valid, !result_valid, "result appeared too early")

endmodule

bind keyframe_curve_interpolator kci_checker u_kci_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .scale_out    (scale_out),
    .status       (status)
);

>>> test/tb_keyframe_curve_interpolator.sv
// ----------------------------------------------------------------------------
// Keyframe curve interpolator testbench
// Drives insert and evaluate words through bursty valid/ready traffic under
// several mode and endpoint settings, predicts every result with a local
// model of the sorted point table, and checks results in order.
// ----------------------------------------------------------------------------
module tb_keyframe_curve_interpolator;
    timeunit 1ns;
    timeprecision 1ps;

    import kci_pkg::*;

    // Mode code 2 has no name in the package; it gives a flat 1.0 result.
    localparam logic [1:0] MODE_FLAT  = 2'd2;
    localparam logic [1:0] MODE_SPARE = 2'd3;
    localparam int         WATCHDOG_LIMIT = 6000;
    localparam int         LONG_HOLD = 400;

    typedef struct {
        logic   act;
        ktime_t t;
        scale_t s;
    } word_t;

    typedef struct {
        scale_t scale;
        logic   st;
    } outcome_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [1:0] cfg_addr = 2'd0;
    logic [15:0] cfg_data = 16'd0;
    logic item_valid = 1'b0;
    logic item_ready;
    logic action = ACT_INSERT;
    ktime_t life_time = '0;
    scale_t point_scale = '0;
    logic result_valid;
    logic result_ready = 1'b0;
    scale_t scale_out;
    logic status;

    keyframe_curve_interpolator u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_addr    (cfg_addr),
        .cfg_data    (cfg_data),
        .item_valid  (item_valid),
        .item_ready  (item_ready),
        .action      (action),
        .life_time   (life_time),
        .point_scale (point_scale),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .scale_out   (scale_out),
        .status      (status)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Local copy of the block state: user points sorted by time.
    longint   pt_time [MAX_POINTS];
    longint   pt_scale[MAX_POINTS];
    int       pt_count = 0;
    logic [1:0] cur_mode = MODE_LINEAR;
    longint   cur_start = 256;
    longint   cur_end = 256;

    word_t    pending_words[$];
    outcome_t expected_results[$];
    int       mismatches = 0;
    bit       hold_go = 0;
    bit       ready_always = 0;

    function automatic longint round_shift(longint v, int sh);
        return (v + (longint'(1) << (sh - 1))) >>> sh;
    endfunction

    function automatic longint clip16(longint v);
        if (v > 32767)
            return 32767;
        if (v < -32768)
            return -32768;
        return v;
    endfunction

    // Inserts a point into the local table; returns the status bit.
    function automatic logic insert_point(longint t, longint s);
        int pos;
        if (t == 0 || t == T_ONE)
            return STATUS_OK;
        for (int i = 0; i < pt_count; i++)
        begin
            if (pt_time[i] == t)
            begin
                pt_scale[i] = s;
                return STATUS_OK;
            end
        end
        if (pt_count >= MAX_POINTS)
            return STATUS_FULL;
        pos = 0;
        while (pos < pt_count && pt_time[pos] < t)
            pos++;
        for (int i = pt_count; i > pos; i--)
        begin
            pt_time[i] = pt_time[i - 1];
            pt_scale[i] = pt_scale[i - 1];
        end
        pt_time[pos] = t;
        pt_scale[pos] = s;
        pt_count++;
        return STATUS_OK;
    endfunction

    // Scale of the curve at time t, with the endpoints merged in.
    function automatic longint curve_scale(longint t);
        longint et[MAX_POINTS + 2];
        longint es[MAX_POINTS + 2];
        int n, k;
        bit end_done;
        longint u, p0, p3, s2, s3, acc;
        n = 1;
        end_done = 0;
        et[0] = 0;
        es[0] = cur_start;
        for (int i = 0; i < pt_count; i++)
        begin
            if (!end_done && pt_time[i] > T_ONE)
            begin
                et[n] = T_ONE;
                es[n] = cur_end;
                n++;
                end_done = 1;
            end
            et[n] = pt_time[i];
            es[n] = pt_scale[i];
            n++;
        end
        if (!end_done)
        begin
            et[n] = T_ONE;
            es[n] = cur_end;
            n++;
        end
        k = 1;
        while (k < n && t >= et[k])
            k++;
        if (k >= n)
            return es[n - 1];
        u = ((t - et[k - 1]) * 65536) / (et[k] - et[k - 1]);
        if (cur_mode == MODE_LINEAR)
            return clip16(es[k - 1] + round_shift((es[k] - es[k - 1]) * u, 16));
        if (cur_mode == MODE_CURVE)
        begin
            p0 = (k >= 2) ? es[k - 2] : es[k - 1];
            p3 = (k + 1 < n) ? es[k + 1] : es[k];
            s2 = round_shift(u * u, 16);
            s3 = round_shift(s2 * u, 16);
            acc = (-s3 + 2 * s2 - u) * p0 + (3 * s3 - 5 * s2 + 131072) * es[k - 1]
                + (-3 * s3 + 4 * s2 + u) * es[k] + (s3 - s2) * p3;
            return clip16(round_shift(acc, 17));
        end
        return SCALE_ONE;
    endfunction

    function automatic outcome_t predict_outcome(word_t w);
        outcome_t o;
        if (w.act == ACT_INSERT)
        begin
            o.scale = '0;
            o.st = insert_point(longint'(w.t), longint'(w.s));
        end
        else
        begin
            o.scale = scale_t'(curve_scale(longint'(w.t)));
            o.st = STATUS_OK;
        end
        return o;
    endfunction

    // Sender: bursts of random length separated by random gaps. The next
    // word is loaded right at the edge where the current one is taken, so
    // valid stays high through a burst.
    int burst_left = 0;
    int gap_left = 0;
    always @(posedge clk or negedge rst_n)
    begin
        word_t w;
        bit busy;
        if (!rst_n)
        begin
            item_valid <= 1'b0;
        end
        else
        begin
            busy = item_valid;
            if (item_valid && item_ready)
            begin
                w.act = action;
                w.t = life_time;
                w.s = point_scale;
                expected_results.push_back(predict_outcome(w));
                busy = 0;
            end
            if (!busy)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (pending_words.size() > 0)
                begin
                    w = pending_words.pop_front();
                    action <= w.act;
                    life_time <= w.t;
                    point_scale <= w.s;
                    busy = 1;
                    if (burst_left == 0)
                    begin
                        burst_left = $urandom_range(1, 30);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                    end
                    else
                        burst_left--;
                end
            end
            item_valid <= busy;
        end
    end

    // Receiver: a random 16-bit ready pattern, replaced now and then, plus
    // one long hold-off requested by the stimulus.
    logic [15:0] ready_pattern = 16'hFFFF;
    int ready_phase = 0;
    int hold_cnt = 0;
    bit hold_started = 0;
    always @(posedge clk or negedge rst_n)
    begin
        bit rdy;
        if (!rst_n)
        begin
            result_ready <= 1'b0;
        end
        else
        begin
            if (hold_go && !hold_started)
            begin
                hold_started = 1;
                hold_cnt = LONG_HOLD;
            end
            ready_phase = (ready_phase + 1) % 16;
            if (ready_phase == 0 && $urandom_range(0, 3) == 0)
                ready_pattern = 16'($urandom_range(0, 65535)) | 16'h0101;
            rdy = ready_always ? 1'b1 : ready_pattern[ready_phase];
            if (hold_cnt > 0)
            begin
                hold_cnt--;
                rdy = 1'b0;
            end
            result_ready <= rdy;
        end
    end

    // Checker: each result word against the oldest expectation.
    always @(posedge clk)
    begin
        outcome_t e;
        if (rst_n && result_valid && result_ready)
        begin
            if (expected_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word: scale %0d status %0b",
                             scale_out, status);
            end
            else
            begin
                e = expected_results.pop_front();
                if (scale_out !== e.scale || status !== e.st)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected scale %0d status %0b, got scale %0d status %0b",
                                 e.scale, e.st, scale_out, status);
                end
            end
        end
    end

    // Watchdog: too many cycles with neither channel moving means a hang.
    int idle_cycles = 0;
    always @(posedge clk)
    begin
        if ((item_valid && item_ready) || (result_valid && result_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Stimulus side of the table: distinct user times handed out so far, so
    // that random inserts mostly hit stored points once the table is full.
    longint used_times[$];

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_MODE)
            cur_mode = val[1:0];
        else if (idx == CFG_START)
            cur_start = longint'($signed(val));
        else
            cur_end = longint'($signed(val));
    endtask

    task automatic queue_word(logic act, longint t, longint s);
        word_t w;
        w.act = act;
        w.t = ktime_t'(t);
        w.s = scale_t'(s);
        if (act == ACT_INSERT && t != 0 && t != T_ONE && used_times.size() < MAX_POINTS)
        begin
            if (!(t inside {used_times}))
                used_times.push_back(t);
        end
        pending_words.push_back(w);
    endtask

    task automatic drain();
        while (pending_words.size() > 0 || item_valid || expected_results.size() > 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    task automatic queue_random(int count);
        longint t;
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 2) == 0)
            begin
                if (used_times.size() > 0 && $urandom_range(0, 3) != 0)
                    t = used_times[$urandom_range(0, used_times.size() - 1)];
                else
                    t = $urandom_range(0, 131071);
                queue_word(ACT_INSERT, t, $urandom_range(0, 65535));
            end
            else
            begin
                // Mostly inside the unit interval, where segments live.
                t = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 131071)
                                                : $urandom_range(0, 65536);
                queue_word(ACT_EVAL, t, $urandom_range(0, 65535));
            end
        end
    endtask

    initial
    begin
        logic [1:0]  modes [6];
        logic [15:0] starts[6];
        logic [15:0] ends  [6];
        modes  = '{MODE_LINEAR, MODE_CURVE, MODE_FLAT, MODE_SPARE, MODE_CURVE, MODE_LINEAR};
        starts = '{16'h8000, 16'h7FFF, 16'd0, 16'h0100, 16'h8000, 16'h7FFF};
        ends   = '{16'h7FFF, 16'h8000, 16'hFFFF, 16'h0100, 16'h8000, 16'h0001};

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (3) @(posedge clk);

        // Directed part at reset settings. An empty table is evaluated first,
        // then endpoint inserts are shown to be accepted but not stored.
        ready_always = 1;
        queue_word(ACT_EVAL, 0, 0);
        queue_word(ACT_EVAL, 32768, 0);
        queue_word(ACT_EVAL, T_ONE, 0);
        queue_word(ACT_EVAL, 131071, 0);
        queue_word(ACT_INSERT, 0, 16'h7FFF);
        queue_word(ACT_INSERT, T_ONE, 16'h8000);
        queue_word(ACT_EVAL, 0, 0);
        queue_word(ACT_INSERT, 32768, 16'h7FFF);
        queue_word(ACT_INSERT, 1, 16'h8000);
        queue_word(ACT_INSERT, 65535, 16'h8000);
        queue_word(ACT_INSERT, 131071, 16'h7FFF);
        queue_word(ACT_INSERT, 98304, 16'h0000);
        queue_word(ACT_EVAL, 1, 0);
        queue_word(ACT_EVAL, 16384, 0);
        queue_word(ACT_EVAL, 65535, 0);
        queue_word(ACT_EVAL, 98304, 0);
        queue_word(ACT_EVAL, 131071, 0);
        // Replacing a stored point keeps the table size.
        queue_word(ACT_INSERT, 32768, 16'hFF00);
        queue_word(ACT_EVAL, 40000, 0);
        drain();
        write_reg(CFG_MODE, MODE_CURVE);
        queue_word(ACT_EVAL, 2, 0);
        queue_word(ACT_EVAL, 50000, 0);
        queue_word(ACT_EVAL, 80000, 0);
        drain();
        ready_always = 0;

        // Random phases, each with its own mode and endpoint scales. The
        // table fills in the first phase and then sees replacements and
        // dropped inserts.
        for (int p = 0; p < 6; p++)
        begin
            write_reg(CFG_MODE, modes[p]);
            write_reg(CFG_START, (p == 3) ? 16'($urandom_range(0, 65535)) : starts[p]);
            write_reg(CFG_END, ends[p]);
            ready_always = (p == 2);
            queue_random(260);
            if (p == 1)
            begin
                // Let the sender back up against a stalled output.
                repeat (20) @(posedge clk);
                hold_go = 1;
            end
            drain();
        end

        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

>>> files.f
+incdir+rtl
rtl/kci_pkg.sv
rtl/kci_ram.sv
rtl/kci_div.sv
rtl/kci_mac.sv
rtl/keyframe_curve_interpolator.sv
rtl/kci_checker.sv
test/tb_keyframe_curve_interpolator.sv
